[design/pir_pkg.sv]
`default_nettype none

package pir_pkg;

   localparam int DEFAULT_SAMPLE_BITS = 12;
   localparam int DATA_W = 16;
   localparam int GAIN_W = 16;
   localparam int LOW_W = 13;
   localparam int HIGH_W = 12;
   localparam int DRIVE_W = 13;
   localparam int CSR_DATA_W = 16;
   localparam int PROP_SHIFT = 12;
   localparam int INTEG_SHIFT = 16;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = GAIN_W'(4096);
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = '0;
   localparam logic signed [LOW_W-1:0] LIMIT_LOW_RESET = -LOW_W'(2047);
   localparam logic [HIGH_W-1:0] LIMIT_HIGH_RESET = HIGH_W'(2048);

   typedef enum logic [1:0] {
      REG_PROP_GAIN = 2'd0,
      REG_INTEG_GAIN = 2'd1,
      REG_LIMIT_LOW = 2'd2,
      REG_LIMIT_HIGH = 2'd3
   } csr_index_type;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic signed [LOW_W-1:0] limit_low;
      logic [HIGH_W-1:0] limit_high;
   } cfg_type;

   function automatic data_type limit_low_ext(cfg_type c);
      return data_type'(c.limit_low);
   endfunction

   function automatic data_type limit_high_ext(cfg_type c);
      return $signed(DATA_W'(c.limit_high));
   endfunction

   function automatic data_type clamp_limits(data_type v, cfg_type c);
      data_type lo;
      data_type hi;
      lo = limit_low_ext(c);
      hi = limit_high_ext(c);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

[design/pir_if.sv]
`default_nettype none

interface pir_req_if import pir_pkg::*; #(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) ();
   logic valid;
   logic ready;
   logic [SAMPLE_BITS-1:0] setpoint;
   logic [SAMPLE_BITS-1:0] measured;

   modport source (output valid, output setpoint, output measured, input ready);
   modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface pir_rsp_if import pir_pkg::*; ();
   logic valid;
   logic ready;
   logic [DRIVE_W-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink (input valid, input drive, output ready);
endinterface

interface pir_csr_if import pir_pkg::*; ();
   logic valid;
   logic ready;
   csr_index_type index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/pir_csr.sv]
`default_nettype none

module pir_csr import pir_pkg::*; (
   input logic clock,
   input logic reset,
   pir_csr_if.sink csr_chan,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_PROP_GAIN: cfg_in.prop_gain = csr_chan.data[GAIN_W-1:0];
            REG_INTEG_GAIN: cfg_in.integ_gain = csr_chan.data[GAIN_W-1:0];
            REG_LIMIT_LOW: cfg_in.limit_low = $signed(csr_chan.data[LOW_W-1:0]);
            REG_LIMIT_HIGH: cfg_in.limit_high = csr_chan.data[HIGH_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain <= PROP_GAIN_RESET;
         cfg_ff.integ_gain <= INTEG_GAIN_RESET;
         cfg_ff.limit_low <= LIMIT_LOW_RESET;
         cfg_ff.limit_high <= LIMIT_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[design/fixed_point_pi_regulator.sv]
// Velocity-form PI regulator, one drive value per request.
// A request passes through the input, term and output registers before its drive value is valid.
// Accepts one request per cycle while the output is not stalled; the accumulator loop closes in the output stage.
// The P and I products are registered before the accumulator update.
// Synchronous reset clears valids, accumulator and previous sample, and loads register defaults.
`default_nettype none

module fixed_point_pi_regulator import pir_pkg::*; #(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input logic clock,
   input logic reset,
   pir_req_if.sink req_chan,
   pir_rsp_if.source rsp_chan,
   pir_csr_if.sink csr_chan
);

   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = GAIN_W + DATA_W + 1;

   cfg_type cfg;

   logic in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sp_ff;
   logic [SAMPLE_BITS-1:0] in_pv_ff;
   logic [SAMPLE_BITS-1:0] prev_ff;

   logic term_valid_ff, term_valid_in;
   data_type p_ff, p_in;
   data_type i_ff, i_in;

   data_type acc_ff, acc_in;

   logic out_valid_ff, out_valid_in;
   logic [DRIVE_W-1:0] drive_ff, drive_in;

   logic req_accept;
   logic in_move;
   logic out_load;

   logic [DIFF_W-1:0] err_wide;
   logic [DIFF_W-1:0] dpv_wide;
   data_type err;
   data_type dpv;
   logic signed [PROD_W-1:0] prop_prod;
   logic signed [PROD_W-1:0] integ_prod;
   data_type sum;
   logic signed [DIFF_W-1:0] drive_sum;

   pir_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr_chan (csr_chan),
      .cfg (cfg)
   );

   assign out_load = term_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign in_move = in_valid_ff && (!term_valid_ff || out_load);
   assign req_chan.ready = !in_valid_ff || in_move;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign in_valid_in = req_accept || (in_valid_ff && !in_move);
   assign term_valid_in = in_move || (term_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);

   // error and measurement step, wrapped to 16 bits; error clamped to the limits, then both scaled by the gains
   always_comb begin
      err_wide = DIFF_W'(in_sp_ff) - DIFF_W'(in_pv_ff);
      dpv_wide = DIFF_W'(in_pv_ff) - DIFF_W'(prev_ff);
      err = clamp_limits($signed(err_wide[DATA_W-1:0]), cfg);
      dpv = $signed(dpv_wide[DATA_W-1:0]);
      prop_prod = PROD_W'($signed({1'b0, cfg.prop_gain})) * PROD_W'(dpv);
      integ_prod = PROD_W'($signed({1'b0, cfg.integ_gain})) * PROD_W'(err);
      p_in = $signed(prop_prod[PROP_SHIFT+DATA_W-1:PROP_SHIFT]);
      i_in = $signed(integ_prod[INTEG_SHIFT+DATA_W-1:INTEG_SHIFT]);
   end

   // accumulate, clamp to the limits, offset by limit_high and floor at zero
   always_comb begin
      sum = acc_ff - p_ff + i_ff;
      acc_in = clamp_limits(sum, cfg);
      drive_sum = $signed(DIFF_W'(cfg.limit_high)) + DIFF_W'(acc_in);
      drive_in = drive_sum[DATA_W] ? '0 : drive_sum[DRIVE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         term_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff <= '0;
         prev_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         term_valid_ff <= term_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_move) begin
            prev_ff <= in_pv_ff;
         end
         if (out_load) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sp_ff <= req_chan.setpoint;
         in_pv_ff <= req_chan.measured;
      end
      if (in_move) begin
         p_ff <= p_in;
         i_ff <= i_in;
      end
      if (out_load) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.drive = drive_ff;

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(out_load)
         && $past(limit_low_ext(cfg)) <= $past(limit_high_ext(cfg))
      |-> acc_ff <= $past(limit_high_ext(cfg)) && acc_ff >= $past(limit_low_ext(cfg)))
      else $error("accumulator left the clamp range");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(out_load) |-> $stable(acc_ff))
      else $error("accumulator moved without a request leaving the term stage");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(in_move) |-> prev_ff == $past(in_pv_ff))
      else $error("previous sample not taken from the advancing request");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(out_load) |-> out_valid_ff && term_valid_ff == $past(in_move))
      else $error("request lost between term and output stage");
`endif

endmodule

`default_nettype wire

[tb/tb_fixed_point_pi_regulator.sv]
`timescale 1ns / 1ps

module tb_fixed_point_pi_regulator;
   import pir_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT = 18;

   class drive_tracker;
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic signed [LOW_W-1:0] limit_low;
      logic [HIGH_W-1:0] limit_high;
      logic signed [DATA_W-1:0] acc;
      logic [11:0] last_measured;
      logic [DRIVE_W-1:0] pending_drive[$];
      int mismatches;
      int matched;

      function new();
         prop_gain = PROP_GAIN_RESET;
         integ_gain = INTEG_GAIN_RESET;
         limit_low = LIMIT_LOW_RESET;
         limit_high = LIMIT_HIGH_RESET;
         acc = '0;
         last_measured = '0;
         mismatches = 0;
         matched = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_PROP_GAIN: prop_gain = data[GAIN_W-1:0];
            REG_INTEG_GAIN: integ_gain = data[GAIN_W-1:0];
            REG_LIMIT_LOW: limit_low = data[LOW_W-1:0];
            REG_LIMIT_HIGH: limit_high = data[HIGH_W-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [DATA_W-1:0] clamp(logic signed [DATA_W-1:0] v);
         logic signed [DATA_W-1:0] lo;
         logic signed [DATA_W-1:0] hi;
         lo = limit_low;
         hi = $signed({4'b0000, limit_high});
         if (v > hi) begin
            return hi;
         end else if (v < lo) begin
            return lo;
         end
         return v;
      endfunction

      function void note_sample(logic [11:0] sp, logic [11:0] pv);
         logic signed [DATA_W-1:0] err;
         logic signed [DATA_W-1:0] dpv;
         logic signed [DATA_W-1:0] pterm;
         logic signed [DATA_W-1:0] iterm;
         logic signed [DATA_W-1:0] sum;
         longint gain;
         longint operand;
         longint prod;
         int level;
         err = $signed({4'b0000, sp}) - $signed({4'b0000, pv});
         err = clamp(err);
         dpv = $signed({4'b0000, pv}) - $signed({4'b0000, last_measured});
         gain = prop_gain;
         operand = dpv;
         prod = (gain * operand) >>> PROP_SHIFT;
         pterm = prod[DATA_W-1:0];
         gain = integ_gain;
         operand = err;
         prod = (gain * operand) >>> INTEG_SHIFT;
         iterm = prod[DATA_W-1:0];
         sum = acc - pterm + iterm;
         acc = clamp(sum);
         last_measured = pv;
         level = int'(limit_high) + int'(acc);
         if (level < 0) begin
            level = 0;
         end
         pending_drive.push_back(level[DRIVE_W-1:0]);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_drive(logic [DRIVE_W-1:0] got);
         logic [DRIVE_W-1:0] want;
         if (pending_drive.size() == 0) begin
            report_mismatch($sformatf("drive %0d with no request outstanding", got));
         end else begin
            want = pending_drive.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("drive %0d, expected %0d", got, want));
            end else begin
               matched++;
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int cycle_count = 0;
   bit calm;
   int samples_sent;
   int settings_used;
   drive_tracker tracker = new();

   pir_req_if req_chan ();
   pir_rsp_if rsp_chan ();
   pir_csr_if csr_chan ();

   fixed_point_pi_regulator dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL fixed_point_pi_regulator");
      $finish;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            tracker.check_drive(rsp_chan.drive);
         end
         if (calm) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   task send_sample(logic [11:0] sp, logic [11:0] pv);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.setpoint <= sp;
      req_chan.measured <= pv;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      tracker.note_sample(sp, pv);
      samples_sent++;
   endtask

   // hold off until every outstanding drive value has arrived
   task drain();
      req_chan.valid <= 1'b0;
      while (tracker.pending_drive.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      tracker.write_reg(idx, data);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task load_config(int prop, int integ, int low, int high);
      logic [CSR_DATA_W-1:0] data;
      int start;
      csr_index_type idx;
      drain();
      @(posedge clock);
      start = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
         idx = csr_index_type'((start + k) % 4);
         data = CSR_DATA_W'($urandom);
         case (idx)
            REG_PROP_GAIN: data = prop[15:0];
            REG_INTEG_GAIN: data = integ[15:0];
            REG_LIMIT_LOW: data[LOW_W-1:0] = low[LOW_W-1:0];
            REG_LIMIT_HIGH: data[HIGH_W-1:0] = high[HIGH_W-1:0];
            default: ;
         endcase
         write_reg(idx, data);
      end
      settings_used++;
   endtask

   task run_directed();
      logic [11:0] sp_list[12];
      logic [11:0] pv_list[12];
      sp_list = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd0,
                  12'd4095, 12'd4095, 12'd1, 12'd2730, 12'd1365, 12'd4095};
      pv_list = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2047, 12'd0,
                  12'd0, 12'd4095, 12'd4094, 12'd1365, 12'd2730, 12'd0};
      for (int k = 0; k < 12; k++) begin
         send_sample(sp_list[k], pv_list[k]);
      end
   endtask

   task run_random(int count);
      int walk;
      int sp;
      for (int k = 0; k < count; k++) begin
         if (k == 0 || $urandom_range(0, 15) == 0) begin
            sp = $urandom_range(0, 4095);
            walk = $urandom_range(0, 4095);
         end
         if ($urandom_range(0, 99) < 70) begin
            walk = walk + $urandom_range(0, 64) - 32;
            if (walk < 0) walk = 0;
            if (walk > 4095) walk = 4095;
            send_sample(sp[11:0], walk[11:0]);
         end else begin
            send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.setpoint <= '0;
      req_chan.measured <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= REG_PROP_GAIN;
      csr_chan.data <= '0;
      calm = 1'b0;
      samples_sent = 0;
      settings_used = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(100);

      load_config(65535, 65535, -4095, 4095);
      run_directed();
      run_random(100);

      // drive floor: deep negative accumulator against a small offset
      load_config(4096, 65535, -4095, 100);
      run_random(120);

      load_config(0, 0, 0, 0);
      run_random(80);

      // crossed limits
      load_config(1000, 20000, 300, 100);
      run_random(100);

      load_config(4096, 32768, -2047, 2048);
      calm = 1'b1;
      run_random(200);
      calm = 1'b0;

      for (int p = 0; p < 7; p++) begin
         load_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                     -$urandom_range(0, 4095), $urandom_range(0, 4095));
         run_random(110);
      end

      drain();
      repeat (12) @(posedge clock);
      if (tracker.pending_drive.size() != 0) begin
         tracker.report_mismatch("drive values still outstanding at end");
      end

      $display("%0d samples sent across %0d register settings", samples_sent, settings_used);
      $display("%0d drive values matched, %0d mismatches", tracker.matched,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("PASS fixed_point_pi_regulator");
      end else begin
         $display("FAIL fixed_point_pi_regulator");
      end
      $finish;
   end

endmodule
